/* rtl/core/ter_pkg.sv */
// Shared types and constants for the timed event ring scheduler.
// Used by the cell, the ring and the top level; depends on nothing.
package ter_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int MAX_FIRES = 64;
  localparam int FW = $clog2(MAX_FIRES) + 1;
  localparam logic [15:0] LOOKAHEAD_RST = 16'd500;
  localparam logic [5:0] CNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;

  localparam logic CFG_ENABLE    = 1'b0;
  localparam logic CFG_LOOKAHEAD = 1'b1;

  typedef struct packed {
    logic        act;
    logic [63:0] due;
    logic [1:0]  typ;
    logic [31:0] tag;
  } entry_t;

endpackage

/* rtl/core/ter_cell.sv */
// One ring cell: holds one event entry and takes its neighbor's entry on a shift.
// Depends on ter_pkg for the entry type.
module ter_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  logic            clr,
  input  ter_pkg::entry_t d_in,
  output ter_pkg::entry_t q
);

  ter_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.act <= 1'b0;
    end else begin
      if (shift) begin
        q_r <= d_in;
      end
      if (clr) begin
        q_r.act <= 1'b0;
      end
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/ter_ring.sv */
// Rotating chain of event cells; cell 0 is the access point of the sequencer.
// Depends on ter_pkg and ter_cell.
module ter_ring #(
  parameter int SLOTS = ter_pkg::SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  logic            clr,
  input  ter_pkg::entry_t fb,
  output ter_pkg::entry_t c0
);

  ter_pkg::entry_t q [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ter_pkg::entry_t d;
    if (i == SLOTS - 1) begin : g_last
      assign d = fb;
    end else begin : g_mid
      assign d = q[i+1];
    end
    ter_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .clr   (clr),
      .d_in  (d),
      .q     (q[i])
    );
  end

  assign c0 = q[0];

endmodule

/* rtl/core/timed_event_ring_scheduler_top.sv */
// Top level of the timed event ring scheduler: sequencer, registers and result port.
// Depends on ter_pkg and ter_ring.
//
// Usage: requests arrive on the in_ channel (valid/ready) as schedule, cancel,
// tick or clear transactions; results leave on the out_ channel (valid/ready).
// Every request gives one result with out_last set, except a tick that fires
// events, which gives one result per fired event in ring order, the final one
// with out_last set. Configuration (enable, lookahead) is written on cfg_.
// Events sit in a ring of SLOTS cells that rotates one cell per cycle while the
// sequencer shifts it; all reads and writes happen at cell 0, so schedule, cancel
// and tick wait for the ring to bring the cells they need to cell 0, and a tick
// also waits for any output stall.
// One request is processed at a time; a new one is accepted once the
// sequencer is idle, even while the previous result still waits at the output.
// A stalled receiver pauses the tick scan at the next fired event.
// Reset empties the ring, disables the engine and sets the lookahead to 500.
module timed_event_ring_scheduler_top #(
  parameter int SLOTS = ter_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_event_time,
  input  logic [1:0]  in_event_type,
  input  logic [31:0] in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic [1:0]  out_fired_type,
  output logic [31:0] out_fired_tag,
  output logic [5:0]  out_cancelled_count,
  output logic [5:0]  out_occupancy,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int FW = ter_pkg::FW;

  typedef enum logic [2:0] {
    S_IDLE, S_SEEK, S_WRITE, S_CANCEL, S_COUNT, S_FIRE, S_REPLY
  } state_t;

  state_t          state_r, after_r;
  logic [IW-1:0]   rot_r, head_r, tail_r, tgt_r, h0_r, nh_r;
  logic            found_r;
  logic [FW-1:0]   n_r, k_r;
  logic            enable_r;
  logic [15:0]     look_r;
  logic [63:0]     tm_r;
  logic [1:0]      ty_r;
  logic [31:0]     tag_r;
  logic [1:0]      rp_kind_r, rp_status_r;
  logic [5:0]      rp_cnt_r;

  logic            out_valid_r, out_last_r;
  logic [1:0]      out_kind_r, out_status_r, out_type_r;
  logic [5:0]      out_slot_r, out_cnt_r, out_occ_r;
  logic [31:0]     out_tag_r;

  ter_pkg::entry_t c0, fb;
  logic            shift, clr, out_free, acc;
  logic            due_ok, fires, match;
  logic [IW-1:0]   rot_next, tail_next;
  logic [IW:0]     occ_w;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign clr      = acc && (ter_pkg::op_t'(in_op) == ter_pkg::OP_CLEAR);

  assign rot_next  = (rot_r == IW'(SLOTS - 1)) ? '0 : rot_r + 1'b1;
  assign tail_next = (tail_r == IW'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign occ_w = (tail_r >= head_r) ? ({1'b0, tail_r} - {1'b0, head_r})
               : ({1'b0, tail_r} + (IW+1)'(SLOTS) - {1'b0, head_r});

  assign due_ok = c0.act && (c0.due <= tm_r);
  assign match  = c0.act && (c0.typ == ty_r);
  assign fires  = due_ok && (state_r == S_FIRE);

  always_comb begin
    fb    = c0;
    shift = 1'b0;
    unique case (state_r)
      S_SEEK:   shift = (rot_r != tgt_r);
      S_WRITE: begin
        shift  = 1'b1;
        fb.act = 1'b1;
        fb.due = tm_r;
        fb.typ = ty_r;
        fb.tag = tag_r;
      end
      S_CANCEL: begin
        shift = (rot_r != tail_r);
        if (match) begin
          fb.act = 1'b0;
        end
      end
      S_COUNT:  shift = (rot_r != tail_r);
      S_FIRE: begin
        shift = (rot_r != tail_r) && (k_r != n_r) && (!due_ok || out_free);
        if (due_ok) begin
          fb.act = 1'b0;
        end
      end
      default:  shift = 1'b0;
    endcase
  end

  ter_ring #(.SLOTS(SLOTS)) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (shift),
    .clr   (clr),
    .fb    (fb),
    .c0    (c0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      look_r   <= ter_pkg::LOOKAHEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ter_pkg::CFG_ENABLE:    enable_r <= cfg_data[0];
        ter_pkg::CFG_LOOKAHEAD: look_r   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      rot_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (shift) begin
        rot_r <= rot_next;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            ty_r        <= in_event_type;
            tag_r       <= in_tag;
            tm_r        <= in_event_time;
            rp_kind_r   <= ter_pkg::KIND_STATUS;
            rp_status_r <= ter_pkg::ST_OK;
            rp_cnt_r    <= '0;
            unique case (ter_pkg::op_t'(in_op))
              ter_pkg::OP_SCHEDULE: begin
                if (!enable_r) begin
                  rp_status_r <= ter_pkg::ST_STOPPED;
                  state_r     <= S_REPLY;
                end else if (tail_next == head_r) begin
                  rp_status_r <= ter_pkg::ST_FULL;
                  state_r     <= S_REPLY;
                end else begin
                  tgt_r   <= tail_r;
                  after_r <= S_WRITE;
                  state_r <= S_SEEK;
                end
              end
              ter_pkg::OP_CANCEL: begin
                tgt_r   <= head_r;
                after_r <= S_CANCEL;
                state_r <= S_SEEK;
              end
              ter_pkg::OP_TICK: begin
                tm_r <= in_event_time + {48'd0, look_r};
                if (!enable_r) begin
                  rp_status_r <= ter_pkg::ST_STOPPED;
                  state_r     <= S_REPLY;
                end else begin
                  tgt_r   <= head_r;
                  h0_r    <= head_r;
                  found_r <= 1'b0;
                  n_r     <= '0;
                  after_r <= S_COUNT;
                  state_r <= S_SEEK;
                end
              end
              ter_pkg::OP_CLEAR: begin
                head_r  <= '0;
                tail_r  <= '0;
                state_r <= S_REPLY;
              end
            endcase
          end
        end
        S_SEEK: begin
          if (rot_r == tgt_r) begin
            state_r <= after_r;
          end
        end
        S_WRITE: begin
          tail_r  <= tail_next;
          state_r <= S_REPLY;
        end
        S_CANCEL: begin
          if (rot_r == tail_r) begin
            state_r <= S_REPLY;
          end else if (match && rp_cnt_r != ter_pkg::CNT_MAX) begin
            rp_cnt_r <= rp_cnt_r + 1'b1;
          end
        end
        S_COUNT: begin
          if (rot_r == tail_r) begin
            head_r <= found_r ? nh_r : tail_r;
            if (n_r == '0) begin
              rp_kind_r <= ter_pkg::KIND_NONE;
              state_r   <= S_REPLY;
            end else begin
              k_r     <= '0;
              tgt_r   <= h0_r;
              after_r <= S_FIRE;
              state_r <= S_SEEK;
            end
          end else if (due_ok && n_r != FW'(ter_pkg::MAX_FIRES)) begin
            n_r <= n_r + 1'b1;
          end else if (c0.act && !found_r) begin
            found_r <= 1'b1;
            nh_r    <= rot_r;
          end
        end
        S_FIRE: begin
          if (rot_r == tail_r || k_r == n_r) begin
            state_r <= S_IDLE;
          end else if (fires && out_free) begin
            k_r            <= k_r + 1'b1;
            out_valid_r    <= 1'b1;
            out_kind_r     <= ter_pkg::KIND_FIRED;
            out_status_r   <= ter_pkg::ST_OK;
            out_slot_r     <= 6'(rot_r);
            out_type_r     <= c0.typ;
            out_tag_r      <= c0.tag;
            out_cnt_r      <= '0;
            out_occ_r      <= 6'(occ_w);
            out_last_r     <= ((k_r + 1'b1) == n_r);
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= rp_kind_r;
            out_status_r <= rp_status_r;
            out_slot_r   <= '0;
            out_type_r   <= '0;
            out_tag_r    <= '0;
            out_cnt_r    <= rp_cnt_r;
            out_occ_r    <= 6'(occ_w);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_status          = out_status_r;
  assign out_slot            = out_slot_r;
  assign out_fired_type      = out_type_r;
  assign out_fired_tag       = out_tag_r;
  assign out_cancelled_count = out_cnt_r;
  assign out_occupancy       = out_occ_r;
  assign out_last            = out_last_r;

endmodule

/* tb/sv/timed_event_ring_scheduler_top_tb.sv */
// Self-checking testbench for timed_event_ring_scheduler_top: directed and random
// transactions, with a scoreboard class that predicts every result from its own ring model.
// Depends on ter_pkg and the RTL of the scheduler; needs no files or arguments.
module timed_event_ring_scheduler_top_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT = 260;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [1:0]  ftype;
    logic [31:0] ftag;
    logic [5:0]  cnt;
    logic [5:0]  occ;
    logic        last;
  } sched_result_t;

  class ring_scoreboard;
    logic [63:0] due[64];
    logic [1:0] typ[64];
    logic [31:0] tagv[64];
    bit act[64];
    logic [5:0] head, tail;
    bit running;
    logic [15:0] lookahead;
    sched_result_t pending_q[$];
    int errors, accepted, results, fired;

    function new();
      foreach (act[i]) act[i] = 0;
      head = '0; tail = '0; running = 0; lookahead = ter_pkg::LOOKAHEAD_RST;
      errors = 0; accepted = 0; results = 0; fired = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == ter_pkg::CFG_ENABLE) running = val[0];
      else lookahead = val;
    endfunction

    function void push(logic [1:0] k, logic [1:0] s, logic [5:0] sl, logic [1:0] ft,
                       logic [31:0] fg, logic [5:0] c, logic l);
      sched_result_t r;
      r.kind = k; r.status = s; r.slot = sl; r.ftype = ft; r.ftag = fg;
      r.cnt = c; r.occ = tail - head; r.last = l;
      pending_q.push_back(r);
    endfunction

    function void note_request(ter_pkg::op_t op, logic [63:0] t, logic [1:0] ty,
                               logic [31:0] tg);
      logic [5:0] i;
      logic [63:0] deadline;
      int cnt;
      logic [5:0] hits[$];
      accepted++;
      case (op)
        ter_pkg::OP_SCHEDULE: begin
          if (!running)
            push(ter_pkg::KIND_STATUS, ter_pkg::ST_STOPPED, '0, '0, '0, '0, 1'b1);
          else if (tail + 6'd1 == head)
            push(ter_pkg::KIND_STATUS, ter_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          else begin
            due[tail] = t; typ[tail] = ty; tagv[tail] = tg; act[tail] = 1;
            tail = tail + 6'd1;
            push(ter_pkg::KIND_STATUS, ter_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
          end
        end
        ter_pkg::OP_CANCEL: begin
          cnt = 0;
          for (i = head; i != tail; i++) begin
            if (act[i] && typ[i] == ty) begin
              act[i] = 0;
              cnt++;
            end
          end
          push(ter_pkg::KIND_STATUS, ter_pkg::ST_OK, '0, '0, '0,
               (cnt > 63) ? ter_pkg::CNT_MAX : 6'(cnt), 1'b1);
        end
        ter_pkg::OP_TICK: begin
          if (!running)
            push(ter_pkg::KIND_STATUS, ter_pkg::ST_STOPPED, '0, '0, '0, '0, 1'b1);
          else begin
            deadline = t + 64'(lookahead);
            for (i = head; i != tail && hits.size() < ter_pkg::MAX_FIRES; i++) begin
              if (act[i] && due[i] <= deadline) begin
                act[i] = 0;
                hits.push_back(i);
              end
            end
            while (head != tail && !act[head]) head = head + 6'd1;
            if (hits.size() == 0)
              push(ter_pkg::KIND_NONE, ter_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
            foreach (hits[k])
              push(ter_pkg::KIND_FIRED, ter_pkg::ST_OK, hits[k], typ[hits[k]],
                   tagv[hits[k]], '0, k == hits.size() - 1);
            fired += hits.size();
          end
        end
        default: begin
          foreach (act[j]) act[j] = 0;
          head = '0; tail = '0;
          push(ter_pkg::KIND_STATUS, ter_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("field %s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t e;
      results++;
      if (pending_q.size() == 0) begin
        $error("result transaction arrived with nothing expected (kind %0d)", got.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      field("kind", 64'(e.kind), 64'(got.kind));
      field("status", 64'(e.status), 64'(got.status));
      field("slot", 64'(e.slot), 64'(got.slot));
      field("fired_type", 64'(e.ftype), 64'(got.ftype));
      field("fired_tag", 64'(e.ftag), 64'(got.ftag));
      field("cancelled_count", 64'(e.cnt), 64'(got.cnt));
      field("occupancy", 64'(e.occ), 64'(got.occ));
      field("last", 64'(e.last), 64'(got.last));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_op = ter_pkg::OP_CLEAR;
  logic [63:0] in_event_time = '0;
  logic [1:0] in_event_type = '0;
  logic [31:0] in_tag = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_kind, out_status, out_fired_type;
  logic [5:0] out_slot, out_cancelled_count, out_occupancy;
  logic [31:0] out_fired_tag;
  logic out_last;
  logic cfg_we = 0;
  logic cfg_index = ter_pkg::CFG_ENABLE;
  logic [15:0] cfg_data = '0;

  ring_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  bit hold_req = 0;
  logic [63:0] now_us = '0;

  timed_event_ring_scheduler_top dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("** timed_event_ring_scheduler_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    sched_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.kind = out_kind; r.status = out_status; r.slot = out_slot;
      r.ftype = out_fired_type; r.ftag = out_fired_tag;
      r.cnt = out_cancelled_count; r.occ = out_occupancy; r.last = out_last;
      sb.check_result(r);
    end
  end

  initial begin
    int pattern;
    int span;
    forever begin
      pattern = $urandom_range(0, 3);
      span = $urandom_range(50, 250);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          out_ready <= 0;
          repeat (600) @(posedge clk);
          hold_req = 0;
        end
        case (pattern)
          0: out_ready <= 1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send(ter_pkg::op_t op, logic [63:0] t, logic [1:0] ty, logic [31:0] tg);
    in_valid <= 1;
    in_op <= op;
    in_event_time <= t;
    in_event_type <= ty;
    in_tag <= tg;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, t, ty, tg);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      send(ter_pkg::OP_SCHEDULE, now_us + 64'($urandom_range(0, 3000)),
           2'($urandom_range(0, 3)), $urandom);
    else if (pick < 52)
      send(ter_pkg::OP_SCHEDULE, rand64(), 2'($urandom_range(0, 3)), $urandom);
    else if (pick < 80) begin
      send(ter_pkg::OP_TICK, now_us, 2'($urandom_range(0, 3)), $urandom);
      now_us = now_us + 64'($urandom_range(0, 1500));
    end else if (pick < 85)
      send(ter_pkg::OP_TICK, rand64(), 2'($urandom_range(0, 3)), $urandom);
    else if (pick < 95)
      send(ter_pkg::OP_CANCEL, rand64(), 2'($urandom_range(0, 3)), $urandom);
    else
      send(ter_pkg::OP_CLEAR, rand64(), 2'($urandom_range(0, 3)), $urandom);
  endtask

  initial begin
    logic [15:0] look_set[6];
    look_set = '{16'd0, 16'd65535, 16'd500, 16'd1, 16'd2000, 16'd0};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Engine stopped after reset: schedule and tick are refused.
    send(ter_pkg::OP_SCHEDULE, 64'd10, 2'd1, 32'h1234_5678);
    send(ter_pkg::OP_TICK, 64'd100, 2'd0, 32'h0);
    send(ter_pkg::OP_CANCEL, 64'd0, 2'd1, 32'h0);
    send(ter_pkg::OP_CLEAR, '1, 2'd3, '1);

    write_reg(ter_pkg::CFG_ENABLE, 16'd1);
    write_reg(ter_pkg::CFG_LOOKAHEAD, 16'd0);
    send(ter_pkg::OP_SCHEDULE, 64'd0, 2'd0, 32'h0);
    send(ter_pkg::OP_SCHEDULE, '1, 2'd3, '1);
    send(ter_pkg::OP_SCHEDULE, 64'd5, 2'd2, 32'hA5A5_5A5A);
    send(ter_pkg::OP_SCHEDULE, 64'd7, 2'd1, 32'h5A5A_A5A5);
    send(ter_pkg::OP_TICK, 64'd0, 2'd0, 32'h0);
    send(ter_pkg::OP_CANCEL, 64'd0, 2'd2, 32'h0);
    send(ter_pkg::OP_TICK, 64'd4, 2'd0, 32'h0);
    send(ter_pkg::OP_TICK, '1, 2'd0, 32'h0);

    // Deadline wraps past the top of the 64-bit range.
    write_reg(ter_pkg::CFG_LOOKAHEAD, 16'd65535);
    send(ter_pkg::OP_SCHEDULE, 64'd100, 2'd1, 32'hDEAD_BEEF);
    send(ter_pkg::OP_SCHEDULE, 64'd70000, 2'd3, 32'hFEED_F00D);
    send(ter_pkg::OP_TICK, 64'hFFFF_FFFF_FFFF_FF00, 2'd0, 32'h0);
    send(ter_pkg::OP_CANCEL, 64'd0, 2'd3, 32'h0);
    send(ter_pkg::OP_CLEAR, 64'd0, 2'd0, 32'h0);

    // Fill the ring while the receiver holds off, then fire everything at once.
    write_reg(ter_pkg::CFG_LOOKAHEAD, 16'd0);
    hold_req = 1;
    for (int k = 0; k < 64; k++)
      send(ter_pkg::OP_SCHEDULE, 64'(k), 2'(k), $urandom);
    send(ter_pkg::OP_TICK, 64'd1000, 2'd0, 32'h0);
    send(ter_pkg::OP_CANCEL, 64'd0, 2'd0, 32'h0);

    foreach (look_set[p]) begin
      write_reg(ter_pkg::CFG_LOOKAHEAD, p == 5 ? 16'($urandom) : look_set[p]);
      if (p == 3) write_reg(ter_pkg::CFG_ENABLE, 16'd0);
      if (p == 4) write_reg(ter_pkg::CFG_ENABLE, 16'd1);
      repeat (p == 3 ? 20 : 70) random_item();
    end

    wait_drained();
    $display("covered %0d request transactions, %0d result transactions, %0d fired events",
             sb.accepted, sb.results, sb.fired);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** timed_event_ring_scheduler_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending_q.size());
      $display("** timed_event_ring_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
